>>> src/pced_pkg.sv
`timescale 1ns / 1ps

package pced_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned EndW    = 20;
  localparam int unsigned PosW    = 20;
  localparam int unsigned LenW    = 9;
  localparam int unsigned ValLenW = 20;
  localparam int unsigned MaxVarintBytes = 5;

  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_KEY      = 3'd1,
    KIND_VALUE    = 3'd2,
    KIND_PAST_END = 3'd3,
    KIND_DROPPED  = 3'd4
  } byte_kind_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             block_start;
    logic [EndW-1:0]  entries_end;
  } in_item_t;

  typedef struct packed {
    byte_kind_e         byte_kind;
    logic [ByteW-1:0]   byte_out;
    logic [PosW-1:0]    field_position;
    logic [LenW-1:0]    shared_len;
    logic [LenW-1:0]    key_len;
    logic [ValLenW-1:0] value_len;
    logic               header_done;
    logic               entry_last;
    logic               corrupt;
  } out_item_t;

  function automatic logic [LenW-1:0] low_len(logic [31:0] v);
    return v[LenW-1:0];
  endfunction

  function automatic logic [ValLenW-1:0] low_val(logic [31:0] v);
    return v[ValLenW-1:0];
  endfunction

endpackage

>>> src/pced_core.sv
`timescale 1ns / 1ps

module pced_core import pced_pkg::*; #(
  parameter int unsigned MAX_KEY_BYTES = 256,
  parameter int unsigned OFFSET_BITS   = 20
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  output out_item_t res_o
);

  localparam int unsigned KeyLenW = $clog2(MAX_KEY_BYTES + 1);
  localparam int unsigned OffW    = OFFSET_BITS;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_SHARED = 7'b0000010,
    PH_SUFFIX = 7'b0000100,
    PH_VLEN   = 7'b0001000,
    PH_KEY    = 7'b0010000,
    PH_VALUE  = 7'b0100000,
    PH_ERROR  = 7'b1000000
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [31:0]        acc_q, acc_d;
  logic [2:0]         cnt_q, cnt_d;
  logic [KeyLenW-1:0] shared_q, shared_d;
  logic [KeyLenW-1:0] suffix_q, suffix_d;
  logic               key_bad_q, key_bad_d;
  logic [OffW-1:0]    value_q, value_d;
  logic [KeyLenW-1:0] key_len_q, key_len_d;
  logic [KeyLenW-1:0] prev_key_q, prev_key_d;
  logic [OffW-1:0]    left_q, left_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [OffW-1:0]    avail_q, avail_d;

  logic [ByteW-1:0]   b;
  logic               blk;
  logic [31:0]        end32;
  phase_e             cur_phase;
  logic [2:0]         cur_cnt;
  logic [OffW-1:0]    cur_avail;
  logic [KeyLenW-1:0] cur_prev;
  logic [31:0]        shifted;
  logic [31:0]        acc_new;
  logic [2:0]         cnt_inc;
  logic [32:0]        key_sum;
  logic [32:0]        pay_sum;
  logic [KeyLenW-1:0] kl_sum;
  logic [OffW-1:0]    left_n;
  logic [31:0]        suffix32;

  assign b        = item_i.data_byte;
  assign blk      = item_i.block_start;
  assign end32    = 32'(item_i.entries_end);
  assign cur_phase = blk ? PH_SHARED : phase_q;
  assign cur_cnt   = blk ? 3'd0 : cnt_q;
  assign cur_avail = blk ? end32[OffW-1:0] : avail_q;
  assign cur_prev  = blk ? '0 : prev_key_q;

  always_comb begin
    case (cur_cnt)
      3'd0:    shifted = {25'd0, b[6:0]};
      3'd1:    shifted = {18'd0, b[6:0], 7'd0};
      3'd2:    shifted = {11'd0, b[6:0], 14'd0};
      3'd3:    shifted = {4'd0, b[6:0], 21'd0};
      default: shifted = {b[3:0], 28'd0};
    endcase
  end

  assign acc_new  = ((cur_cnt == 3'd0) ? 32'd0 : acc_q) | shifted;
  assign cnt_inc  = cur_cnt + 3'd1;
  assign key_sum  = {1'b0, acc_new} + 33'(shared_q);
  assign pay_sum  = {1'b0, acc_new} + 33'(suffix_q);
  assign kl_sum   = shared_q + suffix_q;
  assign left_n   = left_q - OffW'(1);
  assign suffix32 = 32'(suffix_q);

  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    shared_d   = shared_q;
    suffix_d   = suffix_q;
    key_bad_d  = key_bad_q;
    value_d    = value_q;
    key_len_d  = key_len_q;
    prev_key_d = prev_key_q;
    left_d     = left_q;
    pos_d      = pos_q;
    avail_d    = avail_q;

    res_o                = '0;
    res_o.byte_kind      = KIND_PAST_END;
    res_o.byte_out       = b;

    if (cur_phase != PH_IDLE) begin
      phase_d    = cur_phase;
      cnt_d      = cur_cnt;
      prev_key_d = cur_prev;
      avail_d    = (cur_avail != '0) ? cur_avail - OffW'(1) : cur_avail;

      if (cur_phase == PH_ERROR) begin
        res_o.byte_kind = KIND_DROPPED;
        res_o.corrupt   = 1'b1;
      end else if (cur_avail == '0) begin
        if (cur_phase == PH_SHARED && cur_cnt == 3'd0) begin
          res_o.byte_kind = KIND_PAST_END;
        end else begin
          phase_d         = PH_ERROR;
          res_o.byte_kind = KIND_DROPPED;
          res_o.corrupt   = 1'b1;
        end
      end else begin
        unique case (cur_phase)
          PH_KEY, PH_VALUE: begin
            res_o.shared_len     = low_len(32'(shared_q));
            res_o.key_len        = low_len(32'(key_len_q));
            res_o.value_len      = low_val(32'(value_q));
            res_o.byte_kind      = (cur_phase == PH_KEY) ? KIND_KEY : KIND_VALUE;
            res_o.field_position = pos_q;
            pos_d                = pos_q + PosW'(1);
            left_d               = left_n;
            if (left_n == '0) begin
              if (cur_phase == PH_KEY && value_q != '0) begin
                phase_d = PH_VALUE;
                left_d  = value_q;
                pos_d   = '0;
              end else begin
                phase_d          = PH_SHARED;
                res_o.entry_last = 1'b1;
              end
            end
          end
          default: begin
            // header varint byte
            acc_d           = acc_new;
            cnt_d           = cnt_inc;
            res_o.byte_kind = KIND_HEADER;
            if (!b[7]) begin
              cnt_d = 3'd0;
              if (cur_phase == PH_SHARED) begin
                shared_d  = acc_new[KeyLenW-1:0];
                key_bad_d = acc_new > 32'(cur_prev);
                phase_d   = PH_SUFFIX;
              end else if (cur_phase == PH_SUFFIX) begin
                suffix_d  = acc_new[KeyLenW-1:0];
                key_bad_d = key_bad_q || (key_sum > 33'(MAX_KEY_BYTES));
                phase_d   = PH_VLEN;
              end else if (key_bad_q || (pay_sum >= 33'(cur_avail))) begin
                phase_d         = PH_ERROR;
                res_o.byte_kind = KIND_DROPPED;
                res_o.corrupt   = 1'b1;
              end else begin
                res_o.header_done = 1'b1;
                res_o.shared_len  = low_len(32'(shared_q));
                res_o.key_len     = low_len(32'(kl_sum));
                res_o.value_len   = low_val(acc_new);
                prev_key_d        = kl_sum;
                key_len_d         = kl_sum;
                value_d           = acc_new[OffW-1:0];
                if (suffix_q != '0) begin
                  phase_d = PH_KEY;
                  left_d  = suffix32[OffW-1:0];
                  pos_d   = low_val(32'(shared_q));
                end else if (acc_new != 32'd0) begin
                  phase_d = PH_VALUE;
                  left_d  = acc_new[OffW-1:0];
                  pos_d   = '0;
                end else begin
                  phase_d          = PH_SHARED;
                  res_o.entry_last = 1'b1;
                end
              end
            end else if (cnt_inc >= 3'(MaxVarintBytes)) begin
              phase_d         = PH_ERROR;
              res_o.byte_kind = KIND_DROPPED;
              res_o.corrupt   = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      acc_q      <= '0;
      cnt_q      <= '0;
      shared_q   <= '0;
      suffix_q   <= '0;
      key_bad_q  <= 1'b0;
      value_q    <= '0;
      key_len_q  <= '0;
      prev_key_q <= '0;
      left_q     <= '0;
      pos_q      <= '0;
      avail_q    <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      acc_q      <= acc_d;
      cnt_q      <= cnt_d;
      shared_q   <= shared_d;
      suffix_q   <= suffix_d;
      key_bad_q  <= key_bad_d;
      value_q    <= value_d;
      key_len_q  <= key_len_d;
      prev_key_q <= prev_key_d;
      left_q     <= left_d;
      pos_q      <= pos_d;
      avail_q    <= avail_d;
    end
  end

  a_corrupt_is_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.corrupt |-> res_o.byte_kind == KIND_DROPPED)
    else $error("corrupt item not labelled dropped");

  a_error_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !blk && phase_q == PH_ERROR |=> phase_q == PH_ERROR)
    else $error("error state left without block start");

  a_payload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_KEY || phase_q == PH_VALUE |-> left_q != '0)
    else $error("payload phase with no bytes left");

  a_done_is_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.header_done |-> res_o.byte_kind == KIND_HEADER && !res_o.corrupt)
    else $error("header done on non-header item");

endmodule

>>> src/prefix_compressed_entry_decoder_top.sv
`timescale 1ns / 1ps

// Labels the bytes of a prefix-compressed key-value block, one byte per item,
// and reports each entry's shared, key and value lengths plus entry and
// corruption marks. Throughput is one item per clock while the output does
// not stall: the item sits in an input register, one pass of header/payload
// decode logic updates the decoder state and fills the result register, from
// which each result is presented. The per-byte state update is the only loop.
// Stall on the output holds the result register and backs up into the input
// register.

module prefix_compressed_entry_decoder_top import pced_pkg::*; #(
  parameter int unsigned MAX_KEY_BYTES = 256,
  parameter int unsigned OFFSET_BITS   = 20
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      in_vld_q;
  in_item_t  in_q;
  logic      out_vld_q;
  out_item_t out_q;
  out_item_t res;
  logic      advance;
  logic      step;
  logic      in_take;

  assign advance    = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  pced_core #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES),
    .OFFSET_BITS  (OFFSET_BITS)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .item_i(in_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (step) begin
        in_vld_q <= 1'b0;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule
